@@ rtl/gov_pkg.sv @@
// shared types, constants and codes of the grouped online variance block
package gov_pkg;

    localparam int GROUPS_DEF    = 16;
    localparam int FRAC_BITS_DEF = 16;

    localparam int WIDE_W  = 192;
    localparam int OPB_W   = 64;
    localparam int S_DATA_W = 200;
    localparam int M_DATA_W = 216;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_ADD     = 2'd1,
        CMD_MERGE   = 2'd2,
        CMD_EXTRACT = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STS_VALID = 2'd0,
        STS_NULL  = 2'd1,
        STS_NAN   = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        REG_RESULT_KIND = 1'b0,
        REG_NULL_ON_DZ  = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_ctl_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_READ,
        ST_LOAD,
        ST_DISPATCH,
        ST_WAIT,
        ST_ADD1,
        ST_ADD2,
        ST_MRG1,
        ST_MRG2,
        ST_MRG3,
        ST_MRG4,
        ST_MRG5,
        ST_MRG6,
        ST_EXT1,
        ST_EXT2,
        ST_WRITE,
        ST_OUT
    } state_t;

    function automatic logic [63:0] sat64(input logic [WIDE_W-1:0] x);
        logic [63:0] r;
        r = (|x[WIDE_W-1:64]) ? {64{1'b1}} : x[63:0];
        return r;
    endfunction

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

endpackage

@@ rtl/gov_arith.sv @@
// shared shift-add multiplier, restoring divider and square root unit
module gov_arith (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gov_pkg::arith_ctl_t           ctl,
    input  logic [gov_pkg::WIDE_W-1:0]    a_in,
    input  logic [gov_pkg::OPB_W-1:0]     b_in,
    output logic                          done,
    output logic [gov_pkg::WIDE_W-1:0]    res
);

    localparam int W = gov_pkg::WIDE_W;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    gov_pkg::arith_op_t   op_reg, op_next;
    logic [W-1:0]         acc_reg, acc_next;
    logic [W-1:0]         prod_reg, prod_next;
    logic [W-1:0]         res_reg, res_next;
    logic [63:0]          opb_reg, opb_next;
    logic [65:0]          rem_reg, rem_next;
    logic [63:0]          root_reg, root_next;
    logic [7:0]           iter_reg, iter_next;

    logic [33:0] dsh;
    logic [33:0] ddif;
    logic [65:0] ssh;
    logic [65:0] trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        acc_next  = acc_reg;
        prod_next = prod_reg;
        res_next  = res_reg;
        opb_next  = opb_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        iter_next = iter_reg;
        dsh   = {rem_reg[32:0], acc_reg[W-1]};
        ddif  = dsh - {1'b0, opb_reg[32:0]};
        ssh   = {rem_reg[63:0], acc_reg[W-1:W-2]};
        trial = {root_reg, 2'b01};
        if (ctl.start) begin
            busy_next = 1'b1;
            op_next   = ctl.op;
            acc_next  = a_in;
            opb_next  = b_in;
            prod_next = '0;
            rem_next  = '0;
            root_next = '0;
            iter_next = '0;
        end else if (busy_reg) begin
            case (op_reg)
                gov_pkg::OP_MUL: begin
                    if (opb_reg == '0) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        res_next  = prod_reg;
                    end else begin
                        if (opb_reg[0]) prod_next = prod_reg + acc_reg;
                        acc_next = {acc_reg[W-2:0], 1'b0};
                        opb_next = {1'b0, opb_reg[63:1]};
                    end
                end
                gov_pkg::OP_DIV: begin
                    if (dsh >= {1'b0, opb_reg[32:0]}) begin
                        rem_next = {32'b0, ddif};
                        acc_next = {acc_reg[W-2:0], 1'b1};
                    end else begin
                        rem_next = {32'b0, dsh};
                        acc_next = {acc_reg[W-2:0], 1'b0};
                    end
                    iter_next = iter_reg + 8'd1;
                    if (iter_reg == 8'(W - 1)) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        res_next  = acc_next;
                    end
                end
                gov_pkg::OP_SQRT: begin
                    if (ssh >= trial) begin
                        rem_next  = ssh - trial;
                        root_next = {root_reg[62:0], 1'b1};
                    end else begin
                        rem_next  = ssh;
                        root_next = {root_reg[62:0], 1'b0};
                    end
                    acc_next  = {acc_reg[W-3:0], 2'b00};
                    iter_next = iter_reg + 8'd1;
                    if (iter_reg == 8'(W / 2 - 1)) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        res_next  = {{(W-64){1'b0}}, root_next};
                    end
                end
                default: begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= gov_pkg::OP_MUL;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
        end
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        opb_reg  <= opb_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        iter_reg <= iter_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

    // a finish pulse only ever ends a running operation
    a_done_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_next |-> busy_reg)
        else $error("arith finished while idle");

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("arith busy after finish");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.start |=> busy_reg)
        else $error("arith did not start");

endmodule

@@ rtl/grouped_online_variance_core.sv @@
// top level: per-group welford accumulator with pairwise merge and statistic extract
//
//  channel | dir | tdata                                         | tuser
//  s_      | in  | group, value, part_count, part_mean, part_m2  | command
//  m_      | out | out_group, statistic, out_count, out_mean,    | status
//          |     | out_m2, touched                               |
//  cfg_    | in  | write enable, register index, write data      | -
//
// per s_ transaction: clear and null or nan extracts use no arithmetic; an add runs one
// divide and one multiply; a zero-count merge or a merge into an empty group runs none,
// any other merge two divides of 192 quotient bits and four shift-add multiplies;
// an extract runs one divide, with stddev a square root as well; a multiply ends at the
// multiplier's top set bit; every multiply, divide and square root runs on the one shared
// shift-add / restoring divide / sqrt unit
// after reset a clearing pass zeroes the group memory entry by entry; s_tready low meanwhile
// reset is synchronous, active low; config writes are taken at any time
// a finished result waits in the output register; a stalled m_ side holds the final step
module grouped_online_variance_core #(
    parameter int GROUPS    = gov_pkg::GROUPS_DEF,
    parameter int FRAC_BITS = gov_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // group[3:0], value[51:4], part_count[83:52], part_mean[131:84], part_m2[195:132]
    input  logic [gov_pkg::S_DATA_W-1:0]    s_tdata,
    // command[1:0]
    input  logic [1:0]                      s_tuser,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // out_group[3:0], statistic[67:4], out_count[99:68], out_mean[147:100],
    // out_m2[211:148], touched[212]
    output logic [gov_pkg::M_DATA_W-1:0]    m_tdata,
    // status[1:0]
    output logic [1:0]                      m_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_we,
    input  logic [0:0]                      cfg_addr,
    input  logic [1:0]                      cfg_wdata
);

    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int W  = gov_pkg::WIDE_W;
    localparam int EW = 1 + 64 + 48 + 32;

    // group memory entry: touched, m2, mean, count
    logic [EW-1:0] mem [GROUPS];
    logic [EW-1:0] rd_q;
    logic          wr_en;
    logic [GW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [GW-1:0] rd_addr;

    gov_pkg::state_t state_reg, state_next;
    gov_pkg::state_t ret_reg, ret_next;
    logic [GW-1:0]   clr_reg, clr_next;
    logic [1:0]      kind_reg;
    logic            nodz_reg;

    // captured transaction
    gov_pkg::cmd_t   cmd_reg, cmd_next;
    logic [3:0]      g_reg, g_next;
    logic [47:0]     val_reg, val_next;
    logic [31:0]     pc_reg, pc_next;
    logic [47:0]     pm_reg, pm_next;
    logic [63:0]     pm2_reg, pm2_next;

    // working copy of the addressed group
    logic [31:0]     cnt_reg, cnt_next;
    logic [47:0]     mean_reg, mean_next;
    logic [63:0]     m2_reg, m2_next;
    logic            tch_reg, tch_next;
    logic [48:0]     ad_reg, ad_next;
    logic            dneg_reg, dneg_next;
    logic [32:0]     n_reg, n_next;
    logic [63:0]     stat_reg, stat_next;
    gov_pkg::status_t sts_reg, sts_next;

    // output register
    logic                          mv_reg, mv_next;
    logic [gov_pkg::M_DATA_W-1:0]  mdata_reg, mdata_next;
    logic [1:0]                    muser_reg, muser_next;

    gov_pkg::arith_ctl_t  a_ctl;
    logic [W-1:0]         a_a;
    logic [63:0]          a_b;
    logic                 a_done;
    logic [W-1:0]         a_res;

    // helpers
    logic [48:0] delta;
    logic [48:0] err;
    logic [48:0] mean_upd;
    logic [48:0] q49;
    logic [31:0] need;
    logic        sample;
    logic [31:0] dvs;

    gov_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (a_ctl),
        .a_in    (a_a),
        .b_in    (a_b),
        .done    (a_done),
        .res     (a_res)
    );

    assign rd_addr = GW'(g_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_q <= mem[rd_addr];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= 2'd1;
            nodz_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_addr)
                gov_pkg::REG_RESULT_KIND: kind_reg <= cfg_wdata;
                gov_pkg::REG_NULL_ON_DZ:  nodz_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        clr_next   = clr_reg;
        cmd_next   = cmd_reg;
        g_next     = g_reg;
        val_next   = val_reg;
        pc_next    = pc_reg;
        pm_next    = pm_reg;
        pm2_next   = pm2_reg;
        cnt_next   = cnt_reg;
        mean_next  = mean_reg;
        m2_next    = m2_reg;
        tch_next   = tch_reg;
        ad_next    = ad_reg;
        dneg_next  = dneg_reg;
        n_next     = n_reg;
        stat_next  = stat_reg;
        sts_next   = sts_reg;
        mv_next    = mv_reg;
        mdata_next = mdata_reg;
        muser_next = muser_reg;
        wr_en      = 1'b0;
        wr_addr    = GW'(g_reg);
        wr_data    = {tch_reg, m2_reg, mean_reg, cnt_reg};
        a_ctl.start = 1'b0;
        a_ctl.op    = gov_pkg::OP_MUL;
        a_a        = '0;
        a_b        = '0;
        s_tready   = 1'b0;
        delta      = '0;
        err        = '0;
        mean_upd   = '0;
        q49        = '0;
        sample     = kind_reg[0];
        need       = (sample && nodz_reg) ? 32'd2 : 32'd1;
        dvs        = sample ? (cnt_reg - 32'd1) : cnt_reg;

        if (mv_reg && m_tready) mv_next = 1'b0;

        case (state_reg)
            gov_pkg::ST_CLEAR: begin
                // zeroes the group memory entry by entry after reset
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
                clr_next = clr_reg + GW'(1);
                if (clr_reg == GW'(GROUPS - 1)) state_next = gov_pkg::ST_IDLE;
            end
            gov_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd_next = gov_pkg::cmd_t'(s_tuser);
                    g_next   = s_tdata[3:0];
                    val_next = s_tdata[51:4];
                    pc_next  = s_tdata[83:52];
                    pm_next  = s_tdata[131:84];
                    pm2_next = s_tdata[195:132];
                    sts_next  = gov_pkg::STS_VALID;
                    stat_next = '0;
                    state_next = gov_pkg::ST_REDUCE;
                end
            end
            gov_pkg::ST_REDUCE: begin
                // group index modulo GROUPS by repeated subtraction
                if (int'(g_reg) >= GROUPS) g_next = g_reg - 4'(GROUPS);
                else state_next = gov_pkg::ST_READ;
            end
            gov_pkg::ST_READ: state_next = gov_pkg::ST_LOAD;
            gov_pkg::ST_LOAD: begin
                cnt_next  = rd_q[31:0];
                mean_next = rd_q[79:32];
                m2_next   = rd_q[143:80];
                tch_next  = rd_q[144];
                state_next = gov_pkg::ST_DISPATCH;
            end
            gov_pkg::ST_DISPATCH: begin
                case (cmd_reg)
                    gov_pkg::CMD_CLEAR: begin
                        cnt_next = '0; mean_next = '0; m2_next = '0; tch_next = 1'b0;
                        state_next = gov_pkg::ST_WRITE;
                    end
                    gov_pkg::CMD_ADD: begin
                        // saturating count, then |v - mean| / count
                        if (cnt_reg != 32'hFFFF_FFFF) cnt_next = cnt_reg + 32'd1;
                        delta = {val_reg[47], val_reg} - {mean_reg[47], mean_reg};
                        dneg_next = delta[48];
                        ad_next = delta[48] ? (49'd0 - delta) : delta;
                        tch_next = 1'b1;
                        a_ctl.start = 1'b1;
                        a_ctl.op    = gov_pkg::OP_DIV;
                        a_a = {{(W-49){1'b0}}, ad_next};
                        a_b = {32'b0, cnt_next};
                        ret_next = gov_pkg::ST_ADD1;
                        state_next = gov_pkg::ST_WAIT;
                    end
                    gov_pkg::CMD_MERGE: begin
                        tch_next = 1'b1;
                        delta = {pm_reg[47], pm_reg} - {mean_reg[47], mean_reg};
                        dneg_next = delta[48];
                        ad_next = delta[48] ? (49'd0 - delta) : delta;
                        n_next = {1'b0, cnt_reg} + {1'b0, pc_reg};
                        if (pc_reg == '0) begin
                            state_next = gov_pkg::ST_WRITE;
                        end else if (cnt_reg == '0) begin
                            // empty group adopts the partial
                            cnt_next = pc_reg; mean_next = pm_reg; m2_next = pm2_reg;
                            state_next = gov_pkg::ST_WRITE;
                        end else begin
                            a_ctl.start = 1'b1;
                            a_ctl.op    = gov_pkg::OP_MUL;
                            a_a = {{(W-49){1'b0}}, ad_next};
                            a_b = {32'b0, pc_reg};
                            ret_next = gov_pkg::ST_MRG1;
                            state_next = gov_pkg::ST_WAIT;
                        end
                    end
                    default: begin
                        // extract
                        if (!tch_reg || cnt_reg < need) begin
                            sts_next = gov_pkg::STS_NULL;
                            state_next = gov_pkg::ST_OUT;
                        end else if (sample && cnt_reg == 32'd1) begin
                            sts_next = gov_pkg::STS_NAN;
                            state_next = gov_pkg::ST_OUT;
                        end else begin
                            a_ctl.start = 1'b1;
                            a_ctl.op    = gov_pkg::OP_DIV;
                            a_a = {{(W-64){1'b0}}, m2_reg};
                            a_b = {32'b0, dvs};
                            ret_next = gov_pkg::ST_EXT1;
                            state_next = gov_pkg::ST_WAIT;
                        end
                    end
                endcase
            end
            gov_pkg::ST_WAIT: begin
                if (a_done) state_next = ret_reg;
            end
            gov_pkg::ST_ADD1: begin
                // mean step by magnitude, then |delta| * |v - new mean|
                q49 = a_res[48:0];
                mean_upd = dneg_reg ? ({mean_reg[47], mean_reg} - q49)
                                    : ({mean_reg[47], mean_reg} + q49);
                mean_next = mean_upd[47:0];
                err = {val_reg[47], val_reg} - {mean_upd[47], mean_upd[47:0]};
                a_ctl.start = 1'b1;
                a_ctl.op    = gov_pkg::OP_MUL;
                a_a = {{(W-49){1'b0}}, ad_reg};
                a_b = {15'b0, (err[48] ? (49'd0 - err) : err)};
                ret_next = gov_pkg::ST_ADD2;
                state_next = gov_pkg::ST_WAIT;
            end
            gov_pkg::ST_ADD2: begin
                m2_next = gov_pkg::sat_add64(m2_reg, gov_pkg::sat64(a_res >> FRAC_BITS));
                state_next = gov_pkg::ST_WRITE;
            end
            gov_pkg::ST_MRG1: begin
                a_ctl.start = 1'b1;
                a_ctl.op    = gov_pkg::OP_DIV;
                a_a = a_res;
                a_b = {31'b0, n_reg};
                ret_next = gov_pkg::ST_MRG2;
                state_next = gov_pkg::ST_WAIT;
            end
            gov_pkg::ST_MRG2: begin
                q49 = a_res[48:0];
                mean_upd = dneg_reg ? ({mean_reg[47], mean_reg} - q49)
                                    : ({mean_reg[47], mean_reg} + q49);
                mean_next = mean_upd[47:0];
                a_ctl.start = 1'b1;
                a_ctl.op    = gov_pkg::OP_MUL;
                a_a = {{(W-49){1'b0}}, ad_reg};
                a_b = {15'b0, ad_reg};
                ret_next = gov_pkg::ST_MRG3;
                state_next = gov_pkg::ST_WAIT;
            end
            gov_pkg::ST_MRG3: begin
                a_ctl.start = 1'b1;
                a_ctl.op    = gov_pkg::OP_MUL;
                a_a = a_res;
                a_b = {32'b0, cnt_reg};
                ret_next = gov_pkg::ST_MRG4;
                state_next = gov_pkg::ST_WAIT;
            end
            gov_pkg::ST_MRG4: begin
                a_ctl.start = 1'b1;
                a_ctl.op    = gov_pkg::OP_MUL;
                a_a = a_res;
                a_b = {32'b0, pc_reg};
                ret_next = gov_pkg::ST_MRG5;
                state_next = gov_pkg::ST_WAIT;
            end
            gov_pkg::ST_MRG5: begin
                a_ctl.start = 1'b1;
                a_ctl.op    = gov_pkg::OP_DIV;
                a_a = a_res;
                a_b = {31'b0, n_reg};
                ret_next = gov_pkg::ST_MRG6;
                state_next = gov_pkg::ST_WAIT;
            end
            gov_pkg::ST_MRG6: begin
                m2_next = gov_pkg::sat_add64(gov_pkg::sat_add64(m2_reg, pm2_reg),
                                             gov_pkg::sat64(a_res >> FRAC_BITS));
                cnt_next = n_reg[32] ? 32'hFFFF_FFFF : n_reg[31:0];
                state_next = gov_pkg::ST_WRITE;
            end
            gov_pkg::ST_EXT1: begin
                if (kind_reg[1]) begin
                    a_ctl.start = 1'b1;
                    a_ctl.op    = gov_pkg::OP_SQRT;
                    a_a = {{(W-64){1'b0}}, a_res[63:0]} << FRAC_BITS;
                    ret_next = gov_pkg::ST_EXT2;
                    state_next = gov_pkg::ST_WAIT;
                end else begin
                    stat_next = a_res[63:0];
                    state_next = gov_pkg::ST_OUT;
                end
            end
            gov_pkg::ST_EXT2: begin
                stat_next = a_res[63:0];
                state_next = gov_pkg::ST_OUT;
            end
            gov_pkg::ST_WRITE: begin
                wr_en = 1'b1;
                state_next = gov_pkg::ST_OUT;
            end
            gov_pkg::ST_OUT: begin
                // load the output register once it is free
                if (!mv_reg || m_tready) begin
                    mv_next = 1'b1;
                    mdata_next = {3'b0, tch_reg, m2_reg, mean_reg, cnt_reg, stat_reg, g_reg};
                    muser_next = sts_reg;
                    state_next = gov_pkg::ST_IDLE;
                end
            end
            default: state_next = gov_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gov_pkg::ST_CLEAR;
            ret_reg   <= gov_pkg::ST_IDLE;
            clr_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            clr_reg   <= clr_next;
            mv_reg    <= mv_next;
        end
        cmd_reg   <= cmd_next;
        g_reg     <= g_next;
        val_reg   <= val_next;
        pc_reg    <= pc_next;
        pm_reg    <= pm_next;
        pm2_reg   <= pm2_next;
        cnt_reg   <= cnt_next;
        mean_reg  <= mean_next;
        m2_reg    <= m2_next;
        tch_reg   <= tch_next;
        ad_reg    <= ad_next;
        dneg_reg  <= dneg_next;
        n_reg     <= n_next;
        stat_reg  <= stat_next;
        sts_reg   <= sts_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    // null and nan results carry a zero statistic
    a_stat_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != gov_pkg::STS_VALID) |-> (m_tdata[67:4] == '0))
        else $error("nonzero statistic on null or nan");

    // an untouched group holds no items
    a_untouched_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[212]) |-> (m_tdata[99:68] == '0 && m_tdata[211:148] == '0))
        else $error("untouched group with data");

    // the arith unit only reports while the sequencer waits on it
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        a_done |-> (state_reg == gov_pkg::ST_WAIT))
        else $error("arith result outside wait");

    // the group index is in range before the memory is read
    a_group_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gov_pkg::ST_LOAD) |-> (int'(g_reg) < GROUPS))
        else $error("group index out of range");

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the grouped online variance core
module testbench;

    typedef struct packed {
        gov_pkg::cmd_t cmd;
        logic [3:0]    grp;
        logic [47:0]   val;
        logic [31:0]   pc;
        logic [47:0]   pm;
        logic [63:0]   pm2;
    } cmd_item_t;

    typedef struct packed {
        logic [3:0]       grp;
        gov_pkg::status_t sts;
        logic [63:0]      stat;
        logic [31:0]      cnt;
        logic [47:0]      mean;
        logic [63:0]      m2;
        logic             tch;
    } stat_result_t;

    typedef struct packed {
        cmd_item_t    it;
        logic         typed;
        stat_result_t res;
    } dir_row_t;

    localparam int FRAC = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam int PHASE_ITEMS = 150;
    localparam logic [47:0] MAX48 = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] MIN48 = 48'h8000_0000_0000;
    localparam logic [31:0] MAXC = 32'hFFFF_FFFF;
    localparam logic [63:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                          aclk;
    logic                          aresetn;
    logic [gov_pkg::S_DATA_W-1:0]  s_tdata;
    logic [1:0]                    s_tuser;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [gov_pkg::M_DATA_W-1:0]  m_tdata;
    logic [1:0]                    m_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic                          cfg_we;
    gov_pkg::reg_idx_t             cfg_addr;
    logic [1:0]                    cfg_wdata;

    grouped_online_variance_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // mirror of the group accumulators and the two registers
    logic [31:0] acc_count [16];
    longint      acc_mean  [16];
    logic [63:0] acc_m2    [16];
    logic        acc_touched [16];
    logic [1:0]  kind_reg;
    logic        null_dz_reg;

    stat_result_t pending_results [$];
    dir_row_t     dir_rows [$];
    int errors;
    int idle_cycles;
    int n_checked;
    int n_cmd [4];
    int n_status [3];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // clip a wide product or quotient to 64 bits
    function automatic logic [63:0] clip64(logic [191:0] x);
        return (|x[191:64]) ? ONES64 : x[63:0];
    endfunction

    function automatic logic [63:0] add_clip(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? ONES64 : s[63:0];
    endfunction

    function automatic logic [63:0] root_floor(logic [191:0] x);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [191:0] sq;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            sq = {128'd0, c} * {128'd0, c};
            if (sq <= x) r = c;
        end
        return r;
    endfunction

    // applies one command to the mirrored state and returns the expected transaction
    function automatic stat_result_t welford_predict(cmd_item_t it);
        stat_result_t r;
        int           g;
        longint       v, pmean, delta, err;
        logic [63:0]  ad, ae, q, d, var_q;
        logic [191:0] w, n, t;
        logic         sample;
        logic [31:0]  need;
        g = it.grp;
        r = '0;
        r.sts = gov_pkg::STS_VALID;
        case (it.cmd)
            gov_pkg::CMD_CLEAR: begin
                acc_count[g] = '0;
                acc_mean[g] = 0;
                acc_m2[g] = '0;
                acc_touched[g] = 1'b0;
            end
            gov_pkg::CMD_ADD: begin
                v = longint'($signed(it.val));
                if (acc_count[g] != MAXC) acc_count[g]++;
                delta = v - acc_mean[g];
                ad = (delta < 0) ? -delta : delta;
                q = ad / {32'd0, acc_count[g]};
                acc_mean[g] = (delta < 0) ? acc_mean[g] - longint'(q)
                                          : acc_mean[g] + longint'(q);
                err = v - acc_mean[g];
                ae = (err < 0) ? -err : err;
                w = ({128'd0, ad} * {128'd0, ae}) >> FRAC;
                acc_m2[g] = add_clip(acc_m2[g], clip64(w));
                acc_touched[g] = 1'b1;
            end
            gov_pkg::CMD_MERGE: begin
                acc_touched[g] = 1'b1;
                if (it.pc == 0) begin
                    // empty partial only marks the group touched
                end else if (acc_count[g] == 0) begin
                    acc_count[g] = it.pc;
                    acc_mean[g] = longint'($signed(it.pm));
                    acc_m2[g] = it.pm2;
                end else begin
                    pmean = longint'($signed(it.pm));
                    n = {160'd0, acc_count[g]} + {160'd0, it.pc};
                    delta = pmean - acc_mean[g];
                    ad = (delta < 0) ? -delta : delta;
                    q = clip64(({128'd0, ad} * {160'd0, it.pc}) / n);
                    t = {128'd0, ad} * {128'd0, ad};
                    t = t * {160'd0, acc_count[g]};
                    t = t * {160'd0, it.pc};
                    t = (t / n) >> FRAC;
                    acc_mean[g] = (delta < 0) ? acc_mean[g] - longint'(q)
                                              : acc_mean[g] + longint'(q);
                    acc_m2[g] = add_clip(add_clip(acc_m2[g], it.pm2), clip64(t));
                    acc_count[g] = (n > {160'd0, MAXC}) ? MAXC : n[31:0];
                end
            end
            default: begin
                sample = kind_reg[0];
                need = (sample && null_dz_reg) ? 32'd2 : 32'd1;
                if (!acc_touched[g] || acc_count[g] < need) begin
                    r.sts = gov_pkg::STS_NULL;
                end else if (sample && acc_count[g] == 1) begin
                    r.sts = gov_pkg::STS_NAN;
                end else begin
                    d = sample ? {32'd0, acc_count[g]} - 64'd1 : {32'd0, acc_count[g]};
                    var_q = acc_m2[g] / d;
                    r.stat = kind_reg[1] ? root_floor({128'd0, var_q} << FRAC) : var_q;
                end
            end
        endcase
        r.grp = it.grp;
        r.cnt = acc_count[g];
        r.mean = acc_mean[g][47:0];
        r.m2 = acc_m2[g];
        r.tch = acc_touched[g];
        return r;
    endfunction

    // receiver stall pattern: changes mode every so often, including stall-free stretches
    initial begin
        int mode;
        int span;
        int tick;
        m_tready = 1'b0;
        mode = 0;
        span = 0;
        tick = 0;
        forever begin
            @(negedge aclk);
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(64, 512);
            end
            span--;
            tick++;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= tick[0];
                2: m_tready <= ($urandom_range(0, 9) >= 3);
                default: m_tready <= ((tick % 16) >= 10);
            endcase
        end
    end

    // result checker
    always @(posedge aclk) begin
        stat_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected transaction on m_ side");
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                n_checked++;
                if (m_tdata[3:0] !== exp_r.grp) begin
                    $error("out_group exp %0d got %0d", exp_r.grp, m_tdata[3:0]);
                    errors++;
                end
                if (m_tuser !== exp_r.sts) begin
                    $error("status exp %0d got %0d", exp_r.sts, m_tuser);
                    errors++;
                end
                if (m_tdata[67:4] !== exp_r.stat) begin
                    $error("statistic exp %h got %h", exp_r.stat, m_tdata[67:4]);
                    errors++;
                end
                if (m_tdata[99:68] !== exp_r.cnt) begin
                    $error("out_count exp %h got %h", exp_r.cnt, m_tdata[99:68]);
                    errors++;
                end
                if (m_tdata[147:100] !== exp_r.mean) begin
                    $error("out_mean exp %h got %h", exp_r.mean, m_tdata[147:100]);
                    errors++;
                end
                if (m_tdata[211:148] !== exp_r.m2) begin
                    $error("out_m2 exp %h got %h", exp_r.m2, m_tdata[211:148]);
                    errors++;
                end
                if (m_tdata[212] !== exp_r.tch) begin
                    $error("touched exp %0d got %0d", exp_r.tch, m_tdata[212]);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog expired, %0d transactions outstanding",
                         pending_results.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    int burst_left;

    // appends one directed row
    function automatic void add_row(dir_row_t row);
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // drives one item, honoring the burst/gap pattern, and books its expectation
    task automatic send_cmd(cmd_item_t it, logic typed, stat_result_t typed_res);
        stat_result_t p;
        if (burst_left == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end else begin
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {4'd0, it.pm2, it.pm, it.pc, it.val, it.grp};
        do @(posedge aclk); while (!s_tready);
        p = welford_predict(it);
        pending_results.insert(pending_results.size(), typed ? typed_res : p);
        n_cmd[it.cmd]++;
        n_status[p.sts]++;
        burst_left--;
    endtask

    // sender pause: hold until every expected transaction has been seen
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_reg(gov_pkg::reg_idx_t idx, logic [1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx == gov_pkg::REG_RESULT_KIND) kind_reg = data;
        else null_dz_reg = data[0];
    endtask

    function automatic logic [47:0] rand_s48(bit wide);
        if (wide) return 48'({$urandom, $urandom});
        return 48'(longint'($urandom_range(0, 2 ** 21)) - longint'(2 ** 20));
    endfunction

    // random command, mostly adds and extracts on small values
    function automatic cmd_item_t rand_cmd();
        cmd_item_t it;
        int sel;
        sel = $urandom_range(0, 99);
        it.cmd = (sel < 8) ? gov_pkg::CMD_CLEAR : (sel < 50) ? gov_pkg::CMD_ADD :
                 (sel < 70) ? gov_pkg::CMD_MERGE : gov_pkg::CMD_EXTRACT;
        it.grp = 4'($urandom_range(0, 15));
        it.val = rand_s48($urandom_range(0, 9) == 0);
        sel = $urandom_range(0, 9);
        it.pc = (sel == 0) ? 32'd0 : (sel == 1) ? $urandom : $urandom_range(1, 50);
        it.pm = rand_s48($urandom_range(0, 9) == 0);
        it.pm2 = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                             : 64'($urandom_range(0, 2 ** 30));
        return it;
    endfunction

    initial begin
        logic [1:0] kinds [8];
        logic       nulls [8];
        errors = 0;
        n_checked = 0;
        idle_cycles = 0;
        burst_left = 0;
        for (int i = 0; i < 4; i++) n_cmd[i] = 0;
        for (int i = 0; i < 3; i++) n_status[i] = 0;
        for (int i = 0; i < 16; i++) begin
            acc_count[i] = '0;
            acc_mean[i] = 0;
            acc_m2[i] = '0;
            acc_touched[i] = 1'b0;
        end
        kind_reg = 2'd1;
        null_dz_reg = 1'b1;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = gov_pkg::REG_RESULT_KIND;
        cfg_wdata = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed rows under reset config (sample variance, null on divide by zero)
        add_row('{'{gov_pkg::CMD_EXTRACT, 4'd0, 48'd0, 32'd0, 48'd0, 64'd0}, 1'b1,
                  '{4'd0, gov_pkg::STS_NULL, 64'd0, 32'd0, 48'd0, 64'd0, 1'b0}});
        add_row('{'{gov_pkg::CMD_ADD, 4'd1, MAX48, 32'd0, 48'd0, 64'd0}, 1'b1,
                  '{4'd1, gov_pkg::STS_VALID, 64'd0, 32'd1, MAX48, 64'd0, 1'b1}});
        add_row('{'{gov_pkg::CMD_EXTRACT, 4'd1, 48'd0, 32'd0, 48'd0, 64'd0}, 1'b1,
                  '{4'd1, gov_pkg::STS_NULL, 64'd0, 32'd1, MAX48, 64'd0, 1'b1}});
        add_row('{'{gov_pkg::CMD_ADD, 4'd1, MIN48, MAXC, MAX48, ONES64}, 1'b0, '0});
        add_row('{'{gov_pkg::CMD_EXTRACT, 4'd1, 48'd0, 32'd0, 48'd0, 64'd0}, 1'b0, '0});
        // zero-count merge only marks the group touched
        add_row('{'{gov_pkg::CMD_MERGE, 4'd2, MAX48, 32'd0, MAX48, ONES64}, 1'b1,
                  '{4'd2, gov_pkg::STS_VALID, 64'd0, 32'd0, 48'd0, 64'd0, 1'b1}});
        add_row('{'{gov_pkg::CMD_EXTRACT, 4'd2, 48'd0, 32'd0, 48'd0, 64'd0}, 1'b1,
                  '{4'd2, gov_pkg::STS_NULL, 64'd0, 32'd0, 48'd0, 64'd0, 1'b1}});
        // empty group adopts the partial as given
        add_row('{'{gov_pkg::CMD_MERGE, 4'd3, 48'd0, MAXC, MIN48, ONES64}, 1'b1,
                  '{4'd3, gov_pkg::STS_VALID, 64'd0, MAXC, MIN48, ONES64, 1'b1}});
        add_row('{'{gov_pkg::CMD_ADD, 4'd3, MAX48, 32'd0, 48'd0, 64'd0}, 1'b0, '0});
        add_row('{'{gov_pkg::CMD_MERGE, 4'd3, 48'd0, MAXC, MAX48, ONES64}, 1'b0, '0});
        add_row('{'{gov_pkg::CMD_EXTRACT, 4'd3, 48'd0, 32'd0, 48'd0, 64'd0}, 1'b0, '0});
        add_row('{'{gov_pkg::CMD_CLEAR, 4'd3, MAX48, MAXC, MAX48, ONES64}, 1'b1,
                  '{4'd3, gov_pkg::STS_VALID, 64'd0, 32'd0, 48'd0, 64'd0, 1'b0}});
        add_row('{'{gov_pkg::CMD_ADD, 4'd15, 48'd0, 32'd0, 48'd0, 64'd0}, 1'b1,
                  '{4'd15, gov_pkg::STS_VALID, 64'd0, 32'd1, 48'd0, 64'd0, 1'b1}});
        add_row('{'{gov_pkg::CMD_ADD, 4'd15, 48'h0000_0003_0000, 32'd0, 48'd0, 64'd0},
                  1'b0, '0});
        add_row('{'{gov_pkg::CMD_ADD, 4'd15, MIN48, 32'd0, 48'd0, 64'd0}, 1'b0, '0});
        add_row('{'{gov_pkg::CMD_EXTRACT, 4'd15, 48'd0, 32'd0, 48'd0, 64'd0}, 1'b0, '0});
        add_row('{'{gov_pkg::CMD_MERGE, 4'd15, 48'd0, 32'd7, 48'h0000_0010_0000,
                    64'd1000}, 1'b0, '0});
        add_row('{'{gov_pkg::CMD_EXTRACT, 4'd15, 48'd0, 32'd0, 48'd0, 64'd0}, 1'b0, '0});
        foreach (dir_rows[i]) send_cmd(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);
        drain();

        // random phases, each with its own register setting, extremes first
        kinds = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd0, 2'd1, 2'd2};
        nulls = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
        for (int ph = 0; ph < 8; ph++) begin
            if (ph >= 6) begin
                kinds[ph] = 2'($urandom_range(0, 3));
                nulls[ph] = 1'($urandom_range(0, 1));
            end
            write_reg(gov_pkg::REG_RESULT_KIND, kinds[ph]);
            write_reg(gov_pkg::REG_NULL_ON_DZ, {1'b0, nulls[ph]});
            for (int k = 0; k < PHASE_ITEMS; k++) send_cmd(rand_cmd(), 1'b0, '0);
            drain();
        end

        repeat (600) @(posedge aclk);
        $display("ran %0d clears, %0d adds, %0d merges, %0d extracts; %0d transactions checked",
                 n_cmd[gov_pkg::CMD_CLEAR], n_cmd[gov_pkg::CMD_ADD],
                 n_cmd[gov_pkg::CMD_MERGE], n_cmd[gov_pkg::CMD_EXTRACT], n_checked);
        $display("statuses seen: %0d valid, %0d null, %0d nan, over 8 register settings",
                 n_status[gov_pkg::STS_VALID], n_status[gov_pkg::STS_NULL],
                 n_status[gov_pkg::STS_NAN]);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
